@@ src/assert_macros.svh @@
// Assertion macros used by the parser's result buffer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property checked on every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

@@ src/ipv4p_pkg.sv @@
// Types and codes shared by the dotted IPv4 address parser.
package ipv4p_pkg;

  // Parser phase codes.
  localparam logic [2:0] PH_START  = 3'd0;
  localparam logic [2:0] PH_ZERO   = 3'd1;
  localparam logic [2:0] PH_DIGITS = 3'd2;
  localparam logic [2:0] PH_TRAIL  = 3'd3;
  localparam logic [2:0] PH_ERROR  = 3'd4;

  // Radix codes.
  localparam logic [1:0] RADIX_DEC = 2'd0;
  localparam logic [1:0] RADIX_OCT = 2'd1;
  localparam logic [1:0] RADIX_HEX = 2'd2;

  // Slot limits for the last part.
  localparam logic [31:0] MAX_24 = 32'h00ff_ffff;
  localparam logic [31:0] MAX_16 = 32'h0000_ffff;
  localparam logic [31:0] MAX_8  = 32'h0000_00ff;

  // Characters of interest.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;

  localparam int NUM_EARLIER = 3;

  // Parser state carried between characters.
  typedef struct packed {
    logic [2:0]  phase;
    logic [1:0]  radix_code;
    logic [31:0] current_value;
    logic [1:0]  parts_seen;
    logic [NUM_EARLIER-1:0][31:0] earlier_parts;
  } parse_state_t;

  // One result beat.
  typedef struct packed {
    logic [31:0] address;
    logic        valid_res;
  } parse_res_t;

endpackage

@@ src/ipv4p_step.sv @@
// Next-state and result logic for one character of the address parser.
module ipv4p_step (
  input  logic [7:0]             ch,
  input  ipv4p_pkg::parse_state_t st,
  output ipv4p_pkg::parse_state_t st_nxt,
  output ipv4p_pkg::parse_res_t   res
);

  logic        is_dec;
  logic        is_lhex;
  logic        is_uhex;
  logic        is_space;
  logic        run_dig;
  logic [1:0]  dig_radix;
  logic [31:0] cur;
  logic [31:0] asm_v;
  logic        asm_fit;
  logic        phase_ok;

  // Character classes.
  always_comb begin
    is_dec   = (ch >= ipv4p_pkg::CH_ZERO) && (ch <= ipv4p_pkg::CH_NINE);
    is_lhex  = (ch >= ipv4p_pkg::CH_LA) && (ch <= ipv4p_pkg::CH_LF);
    is_uhex  = (ch >= ipv4p_pkg::CH_UA) && (ch <= ipv4p_pkg::CH_UF);
    is_space = (ch == ipv4p_pkg::CH_SPACE) ||
               ((ch >= ipv4p_pkg::CH_TAB) && (ch <= ipv4p_pkg::CH_CR));
  end

  // Assemble the address from the earlier parts and the part in progress.
  always_comb begin
    cur     = st.current_value;
    asm_v   = cur;
    asm_fit = 1'b1;
    unique case (st.parts_seen)
      2'd0: begin
        asm_v = cur;
      end
      2'd1: begin
        asm_fit = (cur <= ipv4p_pkg::MAX_24);
        asm_v   = cur | (st.earlier_parts[0] << 24);
      end
      2'd2: begin
        asm_fit = (cur <= ipv4p_pkg::MAX_16);
        asm_v   = cur | (st.earlier_parts[0] << 24) | (st.earlier_parts[1] << 16);
      end
      default: begin
        asm_fit = (cur <= ipv4p_pkg::MAX_8);
        asm_v   = cur | (st.earlier_parts[0] << 24) | (st.earlier_parts[1] << 16)
                | (st.earlier_parts[2] << 8);
      end
    endcase
    phase_ok = (st.phase == ipv4p_pkg::PH_ZERO) || (st.phase == ipv4p_pkg::PH_DIGITS) ||
               (st.phase == ipv4p_pkg::PH_TRAIL);
  end

  // Phase update, followed by digit collection where the phase calls for it.
  always_comb begin
    st_nxt        = st;
    run_dig       = 1'b0;
    dig_radix     = st.radix_code;
    res.valid_res = phase_ok && asm_fit;
    res.address   = (phase_ok && asm_fit) ? asm_v : 32'd0;

    if (ch == ipv4p_pkg::CH_NUL) begin
      // The terminator ends the string and readies the parser for the next.
      st_nxt.phase         = ipv4p_pkg::PH_START;
      st_nxt.radix_code    = ipv4p_pkg::RADIX_DEC;
      st_nxt.current_value = 32'd0;
      st_nxt.parts_seen    = 2'd0;
    end else begin
      unique case (st.phase)
        ipv4p_pkg::PH_START: begin
          if (!is_dec) begin
            st_nxt.phase = ipv4p_pkg::PH_ERROR;
          end else if (ch == ipv4p_pkg::CH_ZERO) begin
            st_nxt.current_value = 32'd0;
            st_nxt.phase         = ipv4p_pkg::PH_ZERO;
          end else begin
            st_nxt.radix_code    = ipv4p_pkg::RADIX_DEC;
            st_nxt.current_value = {28'd0, ch[3:0]};
            st_nxt.phase         = ipv4p_pkg::PH_DIGITS;
          end
        end
        ipv4p_pkg::PH_ZERO: begin
          st_nxt.phase = ipv4p_pkg::PH_DIGITS;
          if ((ch == ipv4p_pkg::CH_LX) || (ch == ipv4p_pkg::CH_UX)) begin
            st_nxt.radix_code = ipv4p_pkg::RADIX_HEX;
          end else begin
            st_nxt.radix_code = ipv4p_pkg::RADIX_OCT;
            dig_radix         = ipv4p_pkg::RADIX_OCT;
            run_dig           = 1'b1;
          end
        end
        ipv4p_pkg::PH_DIGITS: begin
          run_dig = 1'b1;
        end
        ipv4p_pkg::PH_TRAIL: begin
          st_nxt.phase = ipv4p_pkg::PH_TRAIL;
        end
        default: begin
          st_nxt.phase = ipv4p_pkg::PH_ERROR;
        end
      endcase

      // A character inside or at the end of a part's digits.
      if (run_dig) begin
        priority if (is_dec) begin
          unique case (dig_radix)
            ipv4p_pkg::RADIX_HEX: st_nxt.current_value = (cur << 4) + {28'd0, ch[3:0]};
            ipv4p_pkg::RADIX_OCT: st_nxt.current_value = (cur << 3) + {28'd0, ch[3:0]};
            default: st_nxt.current_value = (cur << 3) + (cur << 1) + {28'd0, ch[3:0]};
          endcase
        end else if ((dig_radix == ipv4p_pkg::RADIX_HEX) && (is_lhex || is_uhex)) begin
          st_nxt.current_value = (cur << 4) | {28'd0, ch[3:0] + 4'd9};
        end else if (ch == ipv4p_pkg::CH_DOT) begin
          if (st.parts_seen == 2'd3) begin
            st_nxt.phase = ipv4p_pkg::PH_ERROR;
          end else begin
            st_nxt.earlier_parts[st.parts_seen] = cur;
            st_nxt.parts_seen                   = st.parts_seen + 2'd1;
            st_nxt.current_value                = 32'd0;
            st_nxt.radix_code                   = ipv4p_pkg::RADIX_DEC;
            st_nxt.phase                        = ipv4p_pkg::PH_START;
          end
        end else if (is_space) begin
          st_nxt.phase = ipv4p_pkg::PH_TRAIL;
        end else begin
          st_nxt.phase = ipv4p_pkg::PH_ERROR;
        end
      end
    end
  end

endmodule

@@ src/ipv4p_out_buf.sv @@
// Two-slot result buffer: an output register with a skid slot behind it.
`include "assert_macros.svh"

module ipv4p_out_buf (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  ipv4p_pkg::parse_res_t push_res,
  output logic                  full,
  output logic                  out_valid,
  input  logic                  out_stall,
  output ipv4p_pkg::parse_res_t out_res
);

  logic                  out_v_r;
  logic                  skid_v_r;
  ipv4p_pkg::parse_res_t out_res_r;
  ipv4p_pkg::parse_res_t skid_res_r;
  logic                  out_free;

  assign out_free  = !out_v_r || !out_stall;
  assign full      = skid_v_r;
  assign out_valid = out_v_r;
  assign out_res   = out_res_r;

  // Valid flags: the skid slot fills only while the output beat is held.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r  <= skid_v_r || push;
      skid_v_r <= 1'b0;
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (out_free) begin
      out_res_r <= skid_v_r ? skid_res_r : push_res;
    end else if (push) begin
      skid_res_r <= push_res;
    end
  end

  `ASSERT_CLK(a_skid_behind_out, (skid_v_r |-> out_v_r), "skid slot full with output empty")
  `ASSERT_CLK(a_no_push_when_full, (push |-> !skid_v_r), "result pushed into a full buffer")
  `ASSERT_CLK(a_invalid_is_zero, ((out_v_r && !out_res_r.valid_res) |-> (out_res_r.address == 32'd0)), "failed parse with nonzero address")

endmodule

@@ src/ipv4_dotted_address_parser.sv @@
// Top level: BSD-style dotted IPv4 address parser, one character per beat.
// Throughput: one character per cycle unless stalled; state update is one logic pass.
// The result of an accepted NUL beat is registered in the output or the skid slot.
// The input stalls only while both result slots (output register and skid) are full.
// Reset (rst_n low, synchronous) clears phase, radix, value, part count, result flags.
module ipv4_dotted_address_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_ch,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_address,
  output logic        out_valid_res
);

  ipv4p_pkg::parse_state_t st_r;
  ipv4p_pkg::parse_state_t st_nxt;
  ipv4p_pkg::parse_res_t   step_res;
  ipv4p_pkg::parse_res_t   out_res;
  logic                    buf_full;
  logic                    in_acc;
  logic                    push;

  assign in_stall = buf_full;
  assign in_acc   = in_valid && !buf_full;
  assign push     = in_acc && (in_ch == ipv4p_pkg::CH_NUL);

  ipv4p_step u_step (
    .ch     (in_ch),
    .st     (st_r),
    .st_nxt (st_nxt),
    .res    (step_res)
  );

  // Parser state; the stored parts are written before use and need no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase         <= ipv4p_pkg::PH_START;
      st_r.radix_code    <= ipv4p_pkg::RADIX_DEC;
      st_r.current_value <= 32'd0;
      st_r.parts_seen    <= 2'd0;
    end else if (in_acc) begin
      st_r.phase         <= st_nxt.phase;
      st_r.radix_code    <= st_nxt.radix_code;
      st_r.current_value <= st_nxt.current_value;
      st_r.parts_seen    <= st_nxt.parts_seen;
      st_r.earlier_parts <= st_nxt.earlier_parts;
    end
  end

  ipv4p_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_res  (step_res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_address   = out_res.address;
  assign out_valid_res = out_res.valid_res;

endmodule
